// ----- src/bfiq_pkg.sv -----
// Package for the bloom filter insert/query block: sizes, state and register codes.
// No dependencies; used by the interfaces and by bloom_filter_insert_query.
`default_nettype none

package bfiq_pkg;

    localparam int MAX_KEYS    = 6;
    localparam int MAX_BITS    = 65536;
    localparam int MIN_BITS    = 8;
    localparam int STORE_BYTES = MAX_BITS / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int KEY_W       = 64;
    localparam int HASH_W      = 32;
    localparam int NKEY_W      = 3;
    localparam int FBITS_W     = 17;
    localparam int KIDX_W      = $clog2(MAX_KEYS);
    localparam int MIX_STEPS   = 9;
    localparam int STEP_W      = $clog2(MIX_STEPS);
    localparam int MOD_BPC     = 4;
    localparam int MOD_CYCLES  = HASH_W / MOD_BPC;
    localparam int MODC_W      = $clog2(MOD_CYCLES);

    typedef logic [HASH_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } bfiq_state_t;

    typedef enum logic [2:0] {
        REG_NUM_KEYS,
        REG_FILTER_BITS,
        REG_KEY_0,
        REG_KEY_1,
        REG_KEY_2,
        REG_KEY_3,
        REG_KEY_4,
        REG_KEY_5
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- src/bfiq_ifs.sv -----
// Handshake channels of the bloom filter block: item input, result output, config writes.
// Depends on bfiq_pkg.
`default_nettype none

interface bfiq_item_if;
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [bfiq_pkg::HASH_W-1:0] item_hash;

    modport source (output valid, output req_type, output item_hash, input ready);
    modport sink   (input valid, input req_type, input item_hash, output ready);
endinterface

interface bfiq_result_if;
    logic valid;
    logic ready;
    logic present;

    modport source (output valid, output present, input ready);
    modport sink   (input valid, input present, output ready);
endinterface

interface bfiq_cfg_if;
    logic                       valid;
    logic                       ready;
    bfiq_pkg::cfg_idx_t         index;
    logic [bfiq_pkg::KEY_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/bloom_filter_insert_query.sv -----
// Bloom filter insert/query block: hash mix, modulo unit and byte-wide bit store.
// Depends on bfiq_pkg and the channels in bfiq_ifs.sv.
//
// After reset the block sweeps the 8192-byte bit store to zero, one byte per
// cycle, and takes no item until done; config writes are taken at all times.
// One item is worked at a time. Each key in use passes through the mix (one
// mix line per cycle), the remainder (4 bits per cycle), the store read and
// a step that tests or writes back the byte. An insert runs these steps for
// every key in use; a query runs them up to its first clear bit or its last
// key, then loads the result register. A finished result waits in that
// register while the next item is accepted.
`default_nettype none

module bloom_filter_insert_query (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfiq_item_if.sink   item,
    bfiq_result_if.source result,
    bfiq_cfg_if.sink    cfg
);
    import bfiq_pkg::*;

    logic [7:0] mem [STORE_BYTES];

    bfiq_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [KIDX_W-1:0]   key_idx_reg, key_idx_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [MODC_W-1:0]   mod_cnt_reg, mod_cnt_next;
    word_t               a_reg, a_next, b_reg, b_next, c_reg, c_next;
    word_t               hash_reg, hash_next;
    logic [FBITS_W-1:0]  rem_reg, rem_next;
    logic                is_query_reg, is_query_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic                present_reg, present_next;
    logic [7:0]          rd_data_reg;

    logic [NKEY_W-1:0]   num_keys_reg;
    logic [FBITS_W-1:0]  filter_bits_reg;
    logic [KEY_W-1:0]    key_reg [MAX_KEYS];

    logic [NKEY_W-1:0]   n_eff;
    logic [FBITS_W-1:0]  mod_eff;
    word_t               mix_a, mix_b, mix_c;
    logic [FBITS_W-1:0]  mod_rem;
    word_t               mod_dv;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                last_key;
    logic                bit_set;
    logic [KIDX_W-1:0]   key_idx_inc;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_keys_reg    <= NKEY_W'(MAX_KEYS);
            filter_bits_reg <= FBITS_W'(MAX_BITS);
            for (int i = 0; i < MAX_KEYS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NUM_KEYS:    num_keys_reg    <= cfg.data[NKEY_W-1:0];
                REG_FILTER_BITS: filter_bits_reg <= cfg.data[FBITS_W-1:0];
                REG_KEY_0:       key_reg[0]      <= cfg.data;
                REG_KEY_1:       key_reg[1]      <= cfg.data;
                REG_KEY_2:       key_reg[2]      <= cfg.data;
                REG_KEY_3:       key_reg[3]      <= cfg.data;
                REG_KEY_4:       key_reg[4]      <= cfg.data;
                REG_KEY_5:       key_reg[5]      <= cfg.data;
            endcase
        end
    end

    always_comb
    begin
        if (num_keys_reg == '0)
            n_eff = NKEY_W'(1);
        else if (num_keys_reg > NKEY_W'(MAX_KEYS))
            n_eff = NKEY_W'(MAX_KEYS);
        else
            n_eff = num_keys_reg;

        if (filter_bits_reg < FBITS_W'(MIN_BITS))
            mod_eff = FBITS_W'(MIN_BITS);
        else if (filter_bits_reg > FBITS_W'(MAX_BITS))
            mod_eff = FBITS_W'(MAX_BITS);
        else
            mod_eff = filter_bits_reg;
    end

    // one mix line per step
    always_comb
    begin
        mix_a = a_reg;
        mix_b = b_reg;
        mix_c = c_reg;
        unique case (step_reg)
            4'd0: mix_a = (a_reg - b_reg - c_reg) ^ (c_reg >> 13);
            4'd1: mix_b = (b_reg - c_reg - a_reg) ^ (a_reg << 8);
            4'd2: mix_c = (c_reg - a_reg - b_reg) ^ (b_reg >> 13);
            4'd3: mix_a = (a_reg - b_reg - c_reg) ^ (c_reg >> 12);
            4'd4: mix_b = (b_reg - c_reg - a_reg) ^ (a_reg << 16);
            4'd5: mix_c = (c_reg - a_reg - b_reg) ^ (b_reg >> 5);
            4'd6: mix_a = (a_reg - b_reg - c_reg) ^ (c_reg >> 3);
            4'd7: mix_b = (b_reg - c_reg - a_reg) ^ (a_reg << 10);
            4'd8: mix_c = (c_reg - a_reg - b_reg) ^ (b_reg >> 15);
            default: ;
        endcase
    end

    // restoring remainder, MOD_BPC dividend bits per cycle
    always_comb
    begin
        logic [FBITS_W:0] t;
        mod_rem = rem_reg;
        mod_dv  = c_reg;
        for (int i = 0; i < MOD_BPC; i++)
        begin
            t      = {mod_rem, mod_dv[HASH_W-1]};
            mod_dv = {mod_dv[HASH_W-2:0], 1'b0};
            if (t >= {1'b0, mod_eff})
                t = t - {1'b0, mod_eff};
            mod_rem = t[FBITS_W-1:0];
        end
    end

    assign last_key    = ({1'b0, key_idx_reg} + 1'b1) == (KIDX_W+1)'(n_eff);
    assign key_idx_inc = key_idx_reg + 1'b1;
    assign bit_set     = rd_data_reg[rem_reg[2:0]];

    assign item.ready     = (state_reg == ST_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.present = present_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        key_idx_next   = key_idx_reg;
        step_next      = step_reg;
        mod_cnt_next   = mod_cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        hash_next      = hash_reg;
        rem_next       = rem_reg;
        is_query_next  = is_query_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        present_next   = present_reg;
        mem_we         = 1'b0;
        mem_waddr      = rem_reg[ADDR_W+2:3];
        mem_wdata      = rd_data_reg | (8'd1 << rem_reg[2:0]);
        mem_re         = 1'b0;
        mem_raddr      = rem_reg[ADDR_W+2:3];

        if (result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    hash_next     = item.item_hash;
                    is_query_next = item.req_type;
                    key_idx_next  = '0;
                    step_next     = '0;
                    a_next        = key_reg[0][HASH_W-1:0];
                    b_next        = key_reg[0][KEY_W-1:HASH_W];
                    c_next        = item.item_hash;
                    state_next    = ST_MIX;
                end
            end
            ST_MIX:
            begin
                a_next    = mix_a;
                b_next    = mix_b;
                c_next    = mix_c;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MIX_STEPS - 1))
                begin
                    rem_next     = '0;
                    mod_cnt_next = '0;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD:
            begin
                rem_next     = mod_rem;
                c_next       = mod_dv;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MODC_W'(MOD_CYCLES - 1))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (is_query_reg && !bit_set)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (last_key)
                begin
                    hit_next   = 1'b1;
                    state_next = is_query_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    key_idx_next = key_idx_inc;
                    step_next    = '0;
                    a_next       = key_reg[key_idx_inc][HASH_W-1:0];
                    b_next       = key_reg[key_idx_inc][KEY_W-1:HASH_W];
                    c_next       = hash_reg;
                    state_next   = ST_MIX;
                end
                if (!is_query_reg)
                    mem_we = 1'b1;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    present_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            key_idx_reg   <= '0;
            step_reg      <= '0;
            mod_cnt_reg   <= '0;
            is_query_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            key_idx_reg   <= key_idx_next;
            step_reg      <= step_next;
            mod_cnt_reg   <= mod_cnt_next;
            is_query_reg  <= is_query_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        hash_reg    <= hash_next;
        rem_reg     <= rem_next;
        present_reg <= present_next;
    end

    // bit store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (rem_reg < mod_eff))
        else $error("remainder not below modulus");

    a_no_query_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_CHECK) |-> !is_query_reg)
        else $error("store written during a query");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

    a_accept_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (state_reg == ST_MIX && step_reg == '0))
        else $error("accepted item did not start the mix");

endmodule

`default_nettype wire
